// ----- src/smau_pkg.sv -----
// ----------------------------------------------------------------------------
// smau_pkg: shared types and constants of the stack machine arithmetic unit
// Operation and status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned DEPTH_W   = 7;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  // binary operations need this many words on the stack
  localparam int unsigned MIN_OPERANDS = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MOD  = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SHORT   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DIVZERO = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_DIVIDE,
    S_WRITE,
    S_RESP
  } smau_state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load;       // capture the transaction
    logic              push_wr;    // write pushed word, count up
    logic              read_a;     // read second element into operand reg
    logic              alu_run;    // add / sub / mul into result reg
    logic              div_start;  // launch the iterative divider
    logic              div_take;   // sign-correct divider output
    logic              op_wr;      // write result, count down
    logic              status_wr;
    logic [STAT_W-1:0] status_val;
  } smau_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_push;
    logic is_binop;
    logic is_divmod;
    logic full;
    logic short_stack;
    logic top_zero;
    logic div_done;
  } smau_stat_t;

endpackage

// ----- src/smau_div.sv -----
// ----------------------------------------------------------------------------
// smau_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Done pulses for one cycle
// after the last step; quotient and remainder then hold until the next start.
// ----------------------------------------------------------------------------
module smau_div
  import smau_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quotient_o,
  output logic [WORD_W-1:0] remainder_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]    quo_q, quo_d;
  logic [WORD_W-1:0]    dvs_q, dvs_d;
  logic [WORD_W:0]      shift;
  logic [WORD_W+1:0]    diff;
  logic                 ge;

  assign shift = {rem_q, quo_q[WORD_W-1]};
  assign diff  = {1'b0, shift} - {2'b00, dvs_q};
  assign ge    = ~diff[WORD_W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[WORD_W-1:0] : shift[WORD_W-1:0];
      quo_d = {quo_q[WORD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- src/smau_datapath.sv -----
// ----------------------------------------------------------------------------
// smau_datapath: stack storage and arithmetic
// Stack memory with a registered top-of-stack copy, operand and result
// registers, combinational add/sub/mul and the iterative divider.
// ----------------------------------------------------------------------------
module smau_datapath
  import smau_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smau_cmd_t           cmd_i,
  output smau_stat_t          stat_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [WORD_W-1:0]   value_i,
  output logic [WORD_W-1:0]   top_value_o,
  output logic [DEPTH_W-1:0]  depth_o,
  output logic [STAT_W-1:0]   status_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem_q [STACK_DEPTH];

  logic [KIND_W-1:0] kind_q;
  logic [WORD_W-1:0] value_q;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] top_q;
  logic [WORD_W-1:0] res_q, res_d;
  logic [CW-1:0]     count_q, count_d;
  logic [STAT_W-1:0] status_q;

  logic [CW-1:0]       count_m2;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [2*WORD_W-1:0] prod;
  logic [WORD_W-1:0]   mag_a, mag_b;
  logic                div_done;
  logic [WORD_W-1:0]   quo, rem;

  assign count_m2 = count_q - CW'(MIN_OPERANDS);
  assign prod     = a_q * top_q;
  assign mag_a    = a_q[WORD_W-1]   ? (~a_q + 1'b1)   : a_q;
  assign mag_b    = top_q[WORD_W-1] ? (~top_q + 1'b1) : top_q;

  smau_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // result register: alu or sign-corrected divider output
  always_comb begin
    res_d = res_q;
    if (cmd_i.alu_run) begin
      unique case (kind_q)
        KIND_ADD: res_d = a_q + top_q;
        KIND_SUB: res_d = a_q - top_q;
        default:  res_d = prod[WORD_W-1:0];
      endcase
    end else if (cmd_i.div_take) begin
      if (kind_q == KIND_DIV) begin
        res_d = (a_q[WORD_W-1] ^ top_q[WORD_W-1]) ? (~quo + 1'b1) : quo;
      end else begin
        res_d = a_q[WORD_W-1] ? (~rem + 1'b1) : rem;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.op_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  assign wr_addr = cmd_i.push_wr ? count_q[AW-1:0] : count_m2[AW-1:0];
  assign wr_data = cmd_i.push_wr ? value_q : res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr || cmd_i.op_wr) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.read_a) begin
      a_q <= mem_q[count_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (cmd_i.push_wr || cmd_i.op_wr) begin
      top_q <= wr_data;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= STATUS_OK;
    end else begin
      count_q <= count_d;
      if (cmd_i.status_wr) begin
        status_q <= cmd_i.status_val;
      end
    end
  end

  assign stat_o.is_push     = (kind_q == KIND_PUSH);
  assign stat_o.is_binop    = (kind_q == KIND_ADD) || (kind_q == KIND_SUB) ||
                              (kind_q == KIND_MUL) || (kind_q == KIND_DIV) ||
                              (kind_q == KIND_MOD);
  assign stat_o.is_divmod   = (kind_q == KIND_DIV) || (kind_q == KIND_MOD);
  assign stat_o.full        = (count_q == CW'(STACK_DEPTH));
  assign stat_o.short_stack = (count_q < CW'(MIN_OPERANDS));
  assign stat_o.top_zero    = (top_q == '0);
  assign stat_o.div_done    = div_done;

  assign top_value_o = (count_q != '0) ? top_q : '0;
  assign depth_o     = DEPTH_W'(count_q);
  assign status_o    = status_q;

endmodule

// ----- src/smau_ctrl.sv -----
// ----------------------------------------------------------------------------
// smau_ctrl: sequencing state machine
// Accepts a transaction, checks it against the stack state, writes a push or
// steps the datapath through fetch, compute and writeback, then strobes the result.
// ----------------------------------------------------------------------------
module smau_ctrl
  import smau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       done_o,
  input  smau_stat_t stat_i,
  output smau_cmd_t  cmd_o
);

  smau_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.is_binop && !stat_i.short_stack &&
            !(stat_i.is_divmod && stat_i.top_zero)) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FETCH: begin
        state_d = stat_i.is_divmod ? S_DIVIDE : S_WRITE;
      end
      S_DIVIDE: begin
        if (stat_i.div_done) state_d = S_WRITE;
      end
      S_WRITE: state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.status_wr  = 1'b1;
          cmd_o.status_val = STATUS_OK;
        end
      end
      S_DECODE: begin
        if (stat_i.is_push) begin
          if (stat_i.full) begin
            cmd_o.status_wr  = 1'b1;
            cmd_o.status_val = STATUS_FULL;
          end else begin
            cmd_o.push_wr = 1'b1;
          end
        end else if (stat_i.is_binop) begin
          if (stat_i.short_stack) begin
            cmd_o.status_wr  = 1'b1;
            cmd_o.status_val = STATUS_SHORT;
          end else if (stat_i.is_divmod && stat_i.top_zero) begin
            cmd_o.status_wr  = 1'b1;
            cmd_o.status_val = STATUS_DIVZERO;
          end else begin
            cmd_o.read_a = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (stat_i.is_divmod) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.alu_run = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_take = stat_i.div_done;
      end
      S_WRITE: begin
        cmd_o.op_wr = 1'b1;
      end
      S_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/stack_machine_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// stack_machine_arithmetic_unit: 32-bit signed stack machine ALU
// Push, add, sub, mul, div and mod on a hardware operand stack.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a transaction is taken on a rising edge with start_i
//   high and busy_o low; kind_i and value_i are sampled on that edge.
//   Result channel: done_o is high for exactly one cycle with top_value_o,
//   depth_o and status_o valid alongside it. The receiver cannot stall;
//   the result must be taken in that cycle.
//   Push, unused kinds and faults are handled in the decode state; add, sub
//   and mul read the second operand from stack memory, compute and write
//   the result back; div and mod run the restoring divider, one quotient
//   bit per cycle, between the operand read and the writeback. busy_o
//   drops in the cycle after done_o.
//   Faults (too few operands, division by zero, push onto a full stack)
//   leave the stack untouched and are reported in status_o.
//   Reset empties the stack (count to zero); stack memory is not cleared,
//   as only entries below the count are ever read.
// ----------------------------------------------------------------------------
module stack_machine_arithmetic_unit
  import smau_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
)(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic        [KIND_W-1:0]  kind_i,
  input  logic signed [WORD_W-1:0]  value_i,
  // result channel
  output logic                      done_o,
  output logic signed [WORD_W-1:0]  top_value_o,
  output logic        [DEPTH_W-1:0] depth_o,
  output logic        [STAT_W-1:0]  status_o
);

  smau_cmd_t         cmd;
  smau_stat_t        stat;
  logic [WORD_W-1:0] top_value;

  // controller: owns the handshake and sequences each transaction
  smau_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // datapath: stack memory, top register, alu and divider
  smau_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .top_value_o (top_value),
    .depth_o     (depth_o),
    .status_o    (status_o)
  );

  assign top_value_o = signed'(top_value);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the stack machine arithmetic unit
// Drives push, add, sub, mul, div, mod and the unused kinds through the
// command channel, predicts every result from a shadow copy of the stack and
// checks each done_o strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import smau_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_NEG_ONE = 32'hffff_ffff;
  localparam int unsigned DRAIN_CYCLES = 60;   // longer than a whole div/mod transaction
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [WORD_W-1:0]  top_value;
    logic [DEPTH_W-1:0] depth;
    logic [STAT_W-1:0]  status;
  } stack_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic        [KIND_W-1:0]  kind_i;
  logic signed [WORD_W-1:0]  value_i;
  logic                      done_o;
  logic signed [WORD_W-1:0]  top_value_o;
  logic        [DEPTH_W-1:0] depth_o;
  logic        [STAT_W-1:0]  status_o;

  // shadow copy of the operand stack, kept in step with accepted commands
  logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
  int unsigned       shadow_count;

  stack_result_t pending_results [$];

  int unsigned idle_pct;
  int unsigned fail_count;
  int unsigned cmd_count;
  int unsigned divmod_count;
  int unsigned fault_count;
  int unsigned peak_depth;

  stack_machine_arithmetic_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .top_value_o(top_value_o),
    .depth_o    (depth_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous hard stop: even every command as a div/mod behind the longest
  // idle gap stays far below this.
  initial begin
    #2000000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: applies one command to the shadow stack and returns the
  // result the unit should report. Faults leave the shadow stack as it is.
  // --------------------------------------------------------------------------
  function automatic stack_result_t stack_step(input logic [KIND_W-1:0] kind,
                                               input logic [WORD_W-1:0] value);
    stack_result_t     res;
    logic [WORD_W-1:0] a, b, mag_a, mag_b, quo, rem, word;
    res.status = STATUS_OK;
    if (kind == KIND_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        shadow_words[shadow_count] = value;
        shadow_count++;
      end
    end else if (kind <= KIND_MOD) begin
      if (shadow_count < MIN_OPERANDS) begin
        res.status = STATUS_SHORT;
      end else begin
        b = shadow_words[shadow_count-1];
        a = shadow_words[shadow_count-2];
        if ((kind == KIND_DIV || kind == KIND_MOD) && b == '0) begin
          res.status = STATUS_DIVZERO;
        end else begin
          // truncating division on magnitudes, signs fixed up afterwards;
          // min-value magnitude stays 0x8000_0000, which gives the wrap
          mag_a = a[WORD_W-1] ? -a : a;
          mag_b = b[WORD_W-1] ? -b : b;
          quo = '0;
          rem = '0;
          if (mag_b != '0) begin
            quo = mag_a / mag_b;
            rem = mag_a % mag_b;
          end
          case (kind)
            KIND_ADD: word = a + b;
            KIND_SUB: word = a - b;
            KIND_MUL: word = a * b;
            KIND_DIV: word = (a[WORD_W-1] ^ b[WORD_W-1]) ? -quo : quo;
            default:  word = a[WORD_W-1] ? -rem : rem;
          endcase
          shadow_words[shadow_count-2] = word;
          shadow_count--;
        end
      end
    end
    res.top_value = (shadow_count > 0) ? shadow_words[shadow_count-1] : '0;
    res.depth     = shadow_count[DEPTH_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // One command transaction. Called at a rising edge; fields and start_i are
  // driven with a single nonblocking assignment each per step, so a start_i
  // that stays high across back-to-back commands is never toggled.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [KIND_W-1:0] kind,
                          input logic [WORD_W-1:0] value);
    int unsigned   gap;
    stack_result_t want;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      // mostly short gaps, some long enough to straddle a whole division
      gap = ($urandom_range(3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    // accepted on this edge
    want = stack_step(kind, value);
    pending_results.push_back(want);
    if (kind <= KIND_MOD) cmd_count++;
    if (kind == KIND_DIV || kind == KIND_MOD) divmod_count++;
    if (want.status != STATUS_OK) fault_count++;
    if (shadow_count > peak_depth) peak_depth = shadow_count;
  endtask

  // mix of extremes, small numbers and zeros so that the sign and
  // divide-by-zero paths all get hit
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WORD_MIN;
      2:       return WORD_MAX;
      3:       return WORD_NEG_ONE;
      4:       return 32'($urandom_range(20)) - 32'd10;
      5:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_binop();
    return KIND_W'($urandom_range(KIND_ADD, KIND_MOD));
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stack_result_t want;
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected result: top %0d depth %0d status %0d",
                   top_value_o, depth_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (top_value_o !== want.top_value || depth_o !== want.depth ||
            status_o !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Mismatch: top %0d/%0d depth %0d/%0d status %0d/%0d (exp/act)",
                     $signed(want.top_value), top_value_o, want.depth, depth_o,
                     want.status, status_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked sequence: short stack, wrap on add, divide and remainder by
  // zero, min-value over -1, sign rules of div/mod, mul wrap, spare kinds.
  task automatic test_directed_edges();
    send_cmd(KIND_ADD, WORD_MAX);        // empty stack
    send_cmd(KIND_PUSH, WORD_MAX);
    send_cmd(KIND_MOD, '0);              // one element only
    send_cmd(KIND_PUSH, 32'd1);
    send_cmd(KIND_ADD, '0);              // wraps to min-value
    send_cmd(KIND_PUSH, '0);
    send_cmd(KIND_DIV, '0);              // zero divisor
    send_cmd(KIND_MOD, WORD_NEG_ONE);    // zero divisor
    send_cmd(KIND_ADD, '0);              // min-value + 0, drops the zero
    send_cmd(KIND_PUSH, WORD_NEG_ONE);
    send_cmd(KIND_DIV, '0);              // min-value / -1 wraps
    send_cmd(KIND_PUSH, WORD_NEG_ONE);
    send_cmd(KIND_MOD, '0);              // min-value % -1 is zero
    send_cmd(KIND_PUSH, -32'sd7);
    send_cmd(KIND_SUB, '0);              // 0 - (-7)
    send_cmd(KIND_PUSH, -32'sd2);
    send_cmd(KIND_DIV, '0);              // truncates toward zero
    send_cmd(KIND_PUSH, 32'd2);
    send_cmd(KIND_MOD, '0);              // remainder keeps dividend's sign
    send_cmd(KIND_PUSH, WORD_MIN);
    send_cmd(KIND_MUL, '0);
    send_cmd(KIND_PUSH, WORD_MAX);
    send_cmd(KIND_MUL, WORD_MIN);        // wraps
    send_cmd(KIND_SPARE_LO, WORD_NEG_ONE);
    send_cmd(KIND_SPARE_HI, WORD_MAX);
    send_cmd(KIND_SUB, '0);              // one element left
  endtask

  // Fill to the top, push against a full stack, then reduce to one element.
  task automatic test_stack_full();
    while (shadow_count < STACK_DEPTH) send_cmd(KIND_PUSH, pick_word());
    repeat (3) send_cmd(KIND_PUSH, pick_word());
    send_cmd(KIND_ADD, pick_word());
    send_cmd(KIND_PUSH, pick_word());
    send_cmd(KIND_PUSH, pick_word());
    while (shadow_count > 1) send_cmd(pick_binop(), pick_word());
    send_cmd(pick_binop(), pick_word());
  endtask

  // Random walk on the stack depth: grow and shrink phases keep most
  // commands well-formed, with a little noise from spare kinds and ops on
  // a short stack.
  task automatic test_random_mix(input int unsigned n_cmds);
    int unsigned sent;
    int unsigned roll;
    bit          growing;
    sent    = 0;
    growing = 1'b1;
    while (sent < n_cmds) begin
      if ($urandom_range(39) == 0) growing = ~growing;
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_cmd(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), $urandom);
      end else begin
        if (shadow_count < MIN_OPERANDS)
          send_cmd(($urandom_range(9) != 0) ? KIND_PUSH : pick_binop(), pick_word());
        else if (roll < (growing ? 70 : 30))
          send_cmd(KIND_PUSH, pick_word());
        else
          send_cmd(pick_binop(), pick_word());
        sent++;
      end
    end
  endtask

  // Same mix with start_i held high throughout.
  task automatic test_back_to_back(input int unsigned n_cmds);
    int unsigned saved_pct;
    saved_pct = idle_pct;
    idle_pct  = 0;
    test_random_mix(n_cmds);
    idle_pct  = saved_pct;
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    kind_i       <= KIND_PUSH;
    value_i      <= '0;
    shadow_count = 0;
    idle_pct     = 11;
    fail_count   = 0;
    cmd_count    = 0;
    divmod_count = 0;
    fault_count  = 0;
    peak_depth   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_stack_full();
    test_random_mix(800);
    test_back_to_back(350);
    test_random_mix(300);

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d arithmetic/push commands, %0d of them div/mod, %0d faulted;",
             cmd_count, divmod_count, fault_count);
    $display("stack reached depth %0d, %0d check failures", peak_depth, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
